// ===== hdl/sbda_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package sbda_pkg;

   localparam int VALUE_W = 32;
   localparam int DIGITS  = 10;
   localparam int BCD_W   = 4 * DIGITS;
   localparam int CNT_W   = $clog2(VALUE_W + 1);
   localparam int NDIG_W  = $clog2(DIGITS + 1);
   localparam int CHAR_W  = 7;

   localparam logic [CHAR_W-1:0] CHAR_ZERO  = 7'h30;
   localparam logic [CHAR_W-1:0] CHAR_MINUS = 7'h2D;

   // conversion result handed from the converter to the character emitter
   typedef struct packed {
      logic              negative;
      logic [NDIG_W-1:0] ndigits;
      logic [BCD_W-1:0]  bcd;
   } conv_result_type;

endpackage

`default_nettype wire

// ===== hdl/sbda_dabble.sv =====
`timescale 1ns / 1ps
`default_nettype none

module sbda_dabble
   import sbda_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   input  wire logic [VALUE_W-1:0] value,
   output logic                    busy,
   output logic                    done,
   output conv_result_type         result
);

   logic               busy_ff, busy_in;
   logic               done_ff, done_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic [VALUE_W-1:0] mag_ff, mag_in;
   logic [BCD_W-1:0]   bcd_ff, bcd_in;
   logic               neg_ff, neg_in;
   logic [BCD_W-1:0]   adj;
   logic [NDIG_W-1:0]  ndig;

   // add three to every digit of five or more before the shift
   always_comb begin
      for (int i = 0; i < DIGITS; i++) begin
         if (bcd_ff[4*i +: 4] >= 4'd5) begin
            adj[4*i +: 4] = bcd_ff[4*i +: 4] + 4'd3;
         end else begin
            adj[4*i +: 4] = bcd_ff[4*i +: 4];
         end
      end
   end

   // number of significant digits, at least one
   always_comb begin
      ndig = NDIG_W'(1);
      for (int i = 1; i < DIGITS; i++) begin
         if (bcd_ff[4*i +: 4] != 4'd0) begin
            ndig = NDIG_W'(i + 1);
         end
      end
   end

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      mag_in  = mag_ff;
      bcd_in  = bcd_ff;
      neg_in  = neg_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_W'(VALUE_W);
         neg_in  = value[VALUE_W-1];
         mag_in  = value[VALUE_W-1] ? (~value + VALUE_W'(1)) : value;
         bcd_in  = '0;
      end else if (busy_ff) begin
         bcd_in = {adj[BCD_W-2:0], mag_ff[VALUE_W-1]};
         mag_in = {mag_ff[VALUE_W-2:0], 1'b0};
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      mag_ff <= mag_in;
      bcd_ff <= bcd_in;
      neg_ff <= neg_in;
   end

   assign busy            = busy_ff;
   assign done            = done_ff;
   assign result.negative = neg_ff;
   assign result.ndigits  = ndig;
   assign result.bcd      = bcd_ff;

endmodule

`default_nettype wire

// ===== hdl/sbda_emit.sv =====
`timescale 1ns / 1ps
`default_nettype none

module sbda_emit
   import sbda_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              load,
   input  wire conv_result_type   result,
   output logic                   busy,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output logic [CHAR_W-1:0]      rsp_out_char,
   output logic                   rsp_is_last
);

   logic              active_ff, active_in;
   logic              sign_ff, sign_in;
   logic [NDIG_W-1:0] left_ff, left_in;
   logic [BCD_W-1:0]  sr_ff, sr_in;
   logic              valid_ff, valid_in;
   logic [CHAR_W-1:0] char_ff, char_in;
   logic              last_ff, last_in;
   logic [BCD_W-1:0]  aligned;
   logic              advance;

   // move the leading digit to the top of the shift register
   always_comb begin
      aligned = result.bcd;
      for (int i = 1; i <= DIGITS; i++) begin
         if (result.ndigits == NDIG_W'(i)) begin
            aligned = result.bcd << (4 * (DIGITS - i));
         end
      end
   end

   assign advance = active_ff && (!valid_ff || !rsp_stall);

   always_comb begin
      active_in = active_ff;
      sign_in   = sign_ff;
      left_in   = left_ff;
      sr_in     = sr_ff;
      char_in   = char_ff;
      last_in   = last_ff;
      valid_in  = valid_ff && rsp_stall;
      if (load) begin
         active_in = 1'b1;
         sign_in   = result.negative;
         left_in   = result.ndigits;
         sr_in     = aligned;
      end else if (advance) begin
         valid_in = 1'b1;
         if (sign_ff) begin
            char_in = CHAR_MINUS;
            last_in = 1'b0;
            sign_in = 1'b0;
         end else begin
            char_in = CHAR_ZERO + {3'b000, sr_ff[BCD_W-1 -: 4]};
            last_in = (left_ff == NDIG_W'(1));
            sr_in   = {sr_ff[BCD_W-5:0], 4'h0};
            left_in = left_ff - NDIG_W'(1);
            if (left_ff == NDIG_W'(1)) begin
               active_in = 1'b0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         valid_ff  <= 1'b0;
         sign_ff   <= 1'b0;
         left_ff   <= '0;
      end else begin
         active_ff <= active_in;
         valid_ff  <= valid_in;
         sign_ff   <= sign_in;
         left_ff   <= left_in;
      end
      sr_ff   <= sr_in;
      char_ff <= char_in;
      last_ff <= last_in;
   end

   assign busy         = active_ff;
   assign rsp_valid    = valid_ff;
   assign rsp_out_char = char_ff;
   assign rsp_is_last  = last_ff;

endmodule

`default_nettype wire

// ===== hdl/signed_binary_to_decimal_ascii.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Prints one 32-bit two's complement integer per req_ transaction as decimal
// ASCII text on the rsp_ channel, most significant character first: a '-'
// for negative values, then the digits with no leading zeros ("0" for zero),
// the final character flagged by rsp_is_last. The most negative value prints
// correctly as "-2147483648". The magnitude is shifted one bit per cycle
// through a double dabble BCD register and then handed off to the character
// emitter; the characters then leave one per cycle while the consumer does
// not stall, 1 to 11 of them. The next transaction is accepted as soon as
// the last character of the previous one sits in the output register, so
// its conversion overlaps any wait on that character.

module signed_binary_to_decimal_ascii
   import sbda_pkg::*;
(
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      req_valid,
   output logic                           req_stall,
   input  wire logic signed [VALUE_W-1:0] req_value,
   output logic                           rsp_valid,
   input  wire logic                      rsp_stall,
   output logic [CHAR_W-1:0]              rsp_out_char,
   output logic                           rsp_is_last
);

   logic            accept;
   logic            conv_busy;
   logic            conv_done;
   logic            emit_busy;
   conv_result_type conv_result;

   // stall requests while converting, handing off, or emitting digits
   assign req_stall = conv_busy || conv_done || emit_busy;
   assign accept    = req_valid && !req_stall;

   // bit-serial binary to bcd conversion
   sbda_dabble u_dabble (
      .clock  (clock),
      .reset  (reset),
      .start  (accept),
      .value  (req_value),
      .busy   (conv_busy),
      .done   (conv_done),
      .result (conv_result)
   );

   // digit-serial character output behind a registered stage
   sbda_emit u_emit (
      .clock        (clock),
      .reset        (reset),
      .load         (conv_done),
      .result       (conv_result),
      .busy         (emit_busy),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_out_char (rsp_out_char),
      .rsp_is_last  (rsp_is_last)
   );

endmodule

`default_nettype wire

// ===== sim/signed_binary_to_decimal_ascii_test.sv =====
`timescale 1ns / 1ps

module signed_binary_to_decimal_ascii_test;
   import sbda_pkg::*;

   // generous bound: ~400 numbers, each up to 11 chars, with receiver stalls
   localparam int CYCLE_LIMIT = 400000;
   // cycles to let pass after the last char before calling it quiet
   localparam int SETTLE_CYCLES = 60;
   localparam int LONG_HOLD_CYCLES = 400;

   // one expected character of the decimal text
   typedef struct packed {
      logic [CHAR_W-1:0] out_char;
      logic              is_last;
   } decimal_char_type;

   logic                clock;
   logic                reset;
   logic                req_valid;
   logic                req_stall;
   logic [VALUE_W-1:0]  req_value;
   logic                rsp_valid;
   logic                rsp_stall;
   logic [CHAR_W-1:0]   rsp_out_char;
   logic                rsp_is_last;

   decimal_char_type    expected_chars[$];
   int                  mismatch_count = 0;
   int                  cycle_count = 0;

   // idling switches for each side and the long receiver hold-off
   bit                  send_idle_on = 1'b1;
   bit                  recv_idle_on = 1'b1;
   int                  hold_cycles = 0;

   signed_binary_to_decimal_ascii uut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_value    (req_value),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_out_char (rsp_out_char),
      .rsp_is_last  (rsp_is_last)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // run watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   // expected text of one number: optional sign, then digits, no leading zeros
   function automatic void predict_decimal_text(input logic [VALUE_W-1:0] value);
      logic [VALUE_W-1:0] magnitude;
      logic [3:0]         digit [DIGITS];
      int                 count;
      int                 i;
      decimal_char_type   c;
      // unsigned negate, so the most negative value stays 2147483648
      magnitude = value[VALUE_W-1] ? -value : value;
      count = 0;
      do begin
         digit[count] = 4'(magnitude % 10);
         count++;
         magnitude = magnitude / 10;
      end while (magnitude != 0);
      if (value[VALUE_W-1]) begin
         c.out_char = CHAR_MINUS;
         c.is_last  = 1'b0;
         expected_chars.push_back(c);
      end
      for (i = count - 1; i >= 0; i--) begin
         c.out_char = CHAR_ZERO + {3'b000, digit[i]};
         c.is_last  = (i == 0);
         expected_chars.push_back(c);
      end
   endfunction

   // offers one number; valid stays high across back-to-back transactions
   task automatic send_value(input logic [VALUE_W-1:0] value);
      int gap;
      gap = send_idle_on ? $urandom_range(0, 14) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_value <= value;
      do @(posedge clock); while (req_stall);
      // transaction taken at this edge
      predict_decimal_text(value);
   endtask

   // stop offering and let every expected char come out
   task automatic wait_for_idle();
      req_valid <= 1'b0;
      while (expected_chars.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // number with a spread of digit counts, signs and decade boundaries
   function automatic logic [VALUE_W-1:0] random_value();
      logic [VALUE_W-1:0] v;
      logic [VALUE_W-1:0] lo;
      logic [VALUE_W-1:0] hi;
      int                 k;
      int                 j;
      v = '0;
      k = $urandom_range(0, 9);
      lo = 1;
      for (j = 0; j < k; j++) lo = lo * 10;
      case ($urandom_range(0, 3))
         0: begin
            v = $urandom();
         end
         1: begin
            v = $urandom_range(0, 40) - 20;
         end
         2: begin
            hi = (k == 9) ? 32'h7FFF_FFFF : lo * 10 - 1;
            v = $urandom_range(hi, lo);
            if ($urandom_range(0, 1)) v = -v;
         end
         default: begin
            // just at or below a power of ten
            v = lo - $urandom_range(0, 1);
            if ($urandom_range(0, 1)) v = -v;
         end
      endcase
      return v;
   endfunction

   // sign, zero, both extremes, every digit, long and short numbers
   task automatic test_directed();
      logic [VALUE_W-1:0] values[$];
      int                 i;
      values = '{32'd0, 32'd1, -32'sd1, 32'd9, 32'd10, -32'sd10, 32'd99, 32'd100,
                 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0001, 32'd1000000000,
                 32'd999999999, -32'sd999999999, 32'd1234567890, -32'sd1234567890,
                 32'h5555_5555, 32'hAAAA_AAAA, -32'sd5, 32'd4000000000};
      for (i = 0; i < values.size(); i++) send_value(values[i]);
      wait_for_idle();
   endtask

   // random numbers in four stretches with different idling on each side
   task automatic test_random();
      int phase;
      int n;
      for (phase = 0; phase < 4; phase++) begin
         send_idle_on = (phase == 0) || (phase == 2);
         recv_idle_on = (phase == 0) || (phase == 3);
         for (n = 0; n < 85; n++) send_value(random_value());
      end
      send_idle_on = 1'b1;
      recv_idle_on = 1'b1;
      wait_for_idle();
   endtask

   // receiver holds off long while numbers keep coming, so the block backs up
   task automatic test_backpressure();
      int n;
      send_idle_on = 1'b0;
      hold_cycles = LONG_HOLD_CYCLES;
      for (n = 0; n < 20; n++) send_value(random_value());
      send_idle_on = 1'b1;
      wait_for_idle();
   endtask

   // receiver: stall draw after each char taken, plus the long hold-off
   initial begin
      int stall_left;
      stall_left = 0;
      rsp_stall <= 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_valid && !rsp_stall)
            stall_left = recv_idle_on ? $urandom_range(0, 14) : 0;
         if (hold_cycles > 0) begin
            rsp_stall <= 1'b1;
            hold_cycles--;
         end else if (stall_left > 0) begin
            rsp_stall <= 1'b1;
            stall_left--;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // compare each char taken with the oldest expectation
   always @(posedge clock) begin
      decimal_char_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_chars.size() == 0) begin
            $error("unexpected char %h is_last %b", rsp_out_char, rsp_is_last);
            mismatch_count++;
         end else begin
            want = expected_chars.pop_front();
            if (rsp_out_char !== want.out_char) begin
               $error("out_char expected %h actual %h", want.out_char, rsp_out_char);
               mismatch_count++;
            end
            if (rsp_is_last !== want.is_last) begin
               $error("is_last expected %b actual %b", want.is_last, rsp_is_last);
               mismatch_count++;
            end
         end
      end
   end

   initial begin
      reset     <= 1'b1;
      req_valid <= 1'b0;
      req_value <= '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      test_directed();
      test_random();
      test_backpressure();

      // chars still owed at the end count as failures
      if (expected_chars.size() != 0) begin
         $error("%0d expected chars never arrived", expected_chars.size());
         mismatch_count++;
      end
      if (mismatch_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
